@@ design/bf3_pkg.sv @@
package bf3_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 128;

  // Column counter indexes the row memory; row counter runs to FRAME_HEIGHT + 1 while draining
  localparam int COL_W = $clog2(FRAME_WIDTH);
  localparam int ROW_W = $clog2(FRAME_HEIGHT + 2);

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int RAM_W = 2 * PIX_W;   // {older row, newer row}

  // Sum of up to nine 8-bit values
  localparam int SUM_W = 12;

  // Reciprocal multipliers, exact for sums below 2^SUM_W
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 14;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(10923);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

  // Divisor select codes
  localparam logic [1:0] DIV_BY4 = 2'd0;
  localparam logic [1:0] DIV_BY6 = 2'd1;
  localparam logic [1:0] DIV_BY9 = 2'd2;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic            drain;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;
  } res_t;

endpackage

@@ design/bf3_ram.sv @@
module bf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/box_filter_3x3_edge_average.sv @@
// 3x3 mean filter for a FRAME_WIDTH x FRAME_HEIGHT RGB frame sent in raster order,
// one pixel per request on the pix channel. Each channel of each result is the truncated
// mean of the in-frame neighbours: /4 at corners, /6 on edges, /9 inside. The result for
// pixel (y, x) comes out with the request at raster position y*W + x + W + 1, so after
// the last pixel send FRAME_WIDTH + 1 drain requests; the last result carries frame_end,
// and the next request starts a new frame. A drain request sent before the frame is
// complete is dropped. Throughput is one request per clock while pix_ready is high:
// the two previous rows live in a single FRAME_WIDTH x 48 memory that is read when a
// request is taken and written back in the following cycle, and successive requests
// touch different columns. A result passes through the stage 1 and stage 2 registers
// into the output queue; the four-entry queue lets input keep flowing while results
// wait, and pix_ready drops only when the queue plus the results in flight fill it.
module box_filter_3x3_edge_average
  import bf3_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  input  pix_t pix,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  // ---------------- Stage 0: position and request intake ----------------
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;

  logic pixel_phase;
  logic col_zero;
  logic take;
  logic emit;
  logic last;
  logic ok_left, ok_right, ok_top, ok_bot;

  always_comb begin
    pixel_phase = row < ROW_W'(FRAME_HEIGHT);
    col_zero    = col == '0;
    // drain requests inside the frame are dropped without effect
    take        = pix_valid && pix_ready && !(pixel_phase && pix.drain);
    emit        = (!col_zero && row != '0) || (col_zero && row >= ROW_W'(2));
    last        = col_zero && row == ROW_W'(FRAME_HEIGHT + 1);

    // which window columns/rows fall inside the frame
    if (col_zero) begin
      // centre is the last column of row - 2
      ok_left  = 1'b1;
      ok_right = 1'b0;
      ok_top   = row >= ROW_W'(3);
      ok_bot   = row <= ROW_W'(FRAME_HEIGHT);
    end else begin
      // centre is (row - 1, col - 1)
      ok_left  = col >= COL_W'(2);
      ok_right = 1'b1;
      ok_top   = row >= ROW_W'(2);
      ok_bot   = row < ROW_W'(FRAME_HEIGHT);
    end

    if (last) begin
      col_next = '0;
      row_next = '0;
    end else if (col == COL_W'(FRAME_WIDTH - 1)) begin
      col_next = '0;
      row_next = row + ROW_W'(1);
    end else begin
      col_next = col + COL_W'(1);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // ---------------- Stage 1: row memory read-modify-write ----------------
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_last;
  logic             s1_pixel;
  logic [PIX_W-1:0] s1_px;
  logic [COL_W-1:0] s1_col;
  logic [3:0]       s1_ok;   // {left, right, top, bot}

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
    if (take) begin
      s1_emit  <= emit;
      s1_last  <= last;
      s1_pixel <= pixel_phase;
      s1_px    <= pixel_phase ? {pix.in_red, pix.in_green, pix.in_blue} : '0;
      s1_col   <= col;
      s1_ok    <= {ok_left, ok_right, ok_top, ok_bot};
    end
  end

  logic             ram_we;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;

  // Word is {older row, newer row}. Write-back shifts the rows: older <- newer, newer <- pixel.
  // The next request always addresses another column, so no forwarding is needed.
  assign ram_we    = s1_valid && s1_pixel;
  assign ram_wdata = {ram_rdata[PIX_W-1:0], s1_px};

  bf3_ram #(
    .WIDTH (RAM_W),
    .DEPTH (FRAME_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // Window columns: row j of a column at [j*PIX_W +: PIX_W], top row first
  logic [3*PIX_W-1:0] wc_left;
  logic [3*PIX_W-1:0] wc_mid;
  logic [3*PIX_W-1:0] new_col;

  assign new_col = {s1_px, ram_rdata[PIX_W-1:0], ram_rdata[RAM_W-1:PIX_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      wc_left <= '0;
      wc_mid  <= '0;
    end else if (s1_valid) begin
      wc_left <= wc_mid;
      wc_mid  <= new_col;
    end
  end

  // masked window sums, index 2 = red, 1 = green, 0 = blue
  logic [SUM_W-1:0]   sum [3];
  logic [3*PIX_W-1:0] cols [3];
  logic [2:0]         col_ok;
  logic [2:0]         row_ok;
  logic [1:0]         div_sel;

  always_comb begin
    cols[0] = wc_left;
    cols[1] = wc_mid;
    cols[2] = new_col;
    col_ok  = {s1_ok[2], 1'b1, s1_ok[3]};   // bit i = column i
    row_ok  = {s1_ok[0], 1'b1, s1_ok[1]};   // bit j = row j
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (col_ok[i] && row_ok[j]) begin
            sum[ch] = sum[ch] + SUM_W'(cols[i][j*PIX_W + ch*CH_W +: CH_W]);
          end
        end
      end
    end
    if (&s1_ok) begin
      div_sel = DIV_BY9;
    end else if (s1_ok[3] == s1_ok[2] || s1_ok[1] == s1_ok[0]) begin
      // one side full, the other cut: 2 x 3
      div_sel = DIV_BY6;
    end else begin
      div_sel = DIV_BY4;
    end
    // both cut on a side pair is impossible; left/right and top/bottom each lose at most one
    if (!(s1_ok[3] && s1_ok[2]) && !(s1_ok[1] && s1_ok[0])) begin
      div_sel = DIV_BY4;
    end
  end

  // ---------------- Stage 2: divide by neighbour count ----------------
  logic             s2_valid;
  logic             s2_last;
  logic [1:0]       s2_div;
  logic [SUM_W-1:0] s2_sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
    if (s1_valid) begin
      s2_last <= s1_last;
      s2_div  <= div_sel;
      for (int ch = 0; ch < 3; ch++) begin
        s2_sum[ch] <= sum[ch];
      end
    end
  end

  logic [PROD_W-1:0] prod [3];
  logic [CH_W-1:0]   mean [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      case (s2_div)
        DIV_BY6: prod[ch] = PROD_W'(s2_sum[ch]) * PROD_W'(RECIP_6);
        DIV_BY9: prod[ch] = PROD_W'(s2_sum[ch]) * PROD_W'(RECIP_9);
        default: prod[ch] = PROD_W'(s2_sum[ch]) << (RECIP_SHIFT - 2);
      endcase
      mean[ch] = prod[ch][RECIP_SHIFT +: CH_W];
    end
  end

  // ---------------- Result queue ----------------
  res_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic              push;
  logic              pop;
  logic [QCNT_W:0]   reserved;

  assign push      = s2_valid;
  assign pop       = res_valid && res_ready;
  assign res_valid = q_count != '0;
  assign res       = q_mem[rd_ptr];

  // queued results plus results still in the pipe
  assign reserved  = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid && s1_emit)
                   + (QCNT_W+1)'(s2_valid);
  assign pix_ready = reserved < (QCNT_W+1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{out_red: mean[2], out_green: mean[1], out_blue: mean[0],
                         frame_end: s2_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + QCNT_W'(1);
        2'b01:   q_count <= q_count - QCNT_W'(1);
        default: q_count <= q_count;
      endcase
    end
  end

`ifndef SYNTHESIS
  // read and write-back never hit the same column in one cycle
  a_no_rmw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && take |-> s1_col != col)
    else $error("row memory read and write to the same column");

  // credit scheme keeps the queue from overflowing
  a_credit: assert property (@(posedge clk) disable iff (rst)
    reserved <= (QCNT_W+1)'(QDEPTH))
    else $error("result queue over-committed");

  // frame end returns the position to the top left
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    take && last |=> col == '0 && row == '0)
    else $error("position not cleared after frame end");

  // a marked result only follows the last drain request
  a_mark: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_last |-> $past(s1_last, 1) && $past(take, 2))
    else $error("frame end marked without last drain request");
`endif

endmodule
